### rtl/sha1_stream_hasher_macros.svh
// assertion macros used by the sha1 stream hasher core
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHA1SH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sha1sh check failed");

// next-cycle implication, checked out of reset
`define SHA1SH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sha1sh check failed");

`endif

### rtl/sha1sh_pkg.sv
// types and constants of the sha1 stream hasher
`default_nettype none
package sha1sh_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_ABSORB = 2'd1,
        CMD_FINAL  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DIGEST  = 2'd0,
        ST_DONE    = 2'd1,
        ST_CAP     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD2,
        S_EMIT
    } core_state_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_PAD2,
        TAIL_EMIT
    } tail_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } cmd_beat_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  word_index;
        logic [31:0] digest_word;
        logic        last_word;
    } res_beat_t;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage
`default_nettype wire

### rtl/sha1sh_front.sv
// front end: takes command beats, drops unused codes, queues the rest
`default_nettype none
module sha1sh_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [7:0]             s_tdata,
    input  wire  [1:0]             s_tuser,
    output logic                   q_valid,
    input  wire                    q_ready,
    output sha1sh_pkg::cmd_beat_t  q_beat
);
    import sha1sh_pkg::*;

    cmd_beat_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        known;
    logic        push, pop;

    always_comb begin
        known = (s_tuser == CMD_START) || (s_tuser == CMD_ABSORB) || (s_tuser == CMD_FINAL);
        s_tready = (cnt_reg != 2'd2);
        push = s_tvalid && s_tready && known;
        q_valid = (cnt_reg != 2'd0);
        pop = q_valid && q_ready;
        q_beat = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{cmd: cmd_t'(s_tuser), data: s_tdata};
        end
    end

endmodule
`default_nettype wire

### rtl/sha1sh_core.sv
// back end: block buffer, round engine, padding and digest output
`default_nettype none
`include "sha1_stream_hasher_macros.svh"
module sha1sh_core #(
    parameter int COUNT_WIDTH = 61
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    q_valid,
    output logic                   q_ready,
    input  sha1sh_pkg::cmd_beat_t  q_beat,
    output logic                   out_valid,
    input  wire                    out_ready,
    output sha1sh_pkg::res_beat_t  out_beat
);
    import sha1sh_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CAP = {COUNT_WIDTH{1'b1}};

    core_state_t             state_reg, state_next;
    tail_t                   tail_reg, tail_next;
    logic [6:0]              rnd_reg, rnd_next;
    logic [31:0]             a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]             a_next, b_next, c_next, d_next, e_next;
    logic [31:0]             h_reg [5];
    logic [31:0]             h_next [5];
    logic [31:0]             w_reg [16];
    logic [31:0]             w_next [16];
    logic [5:0]              fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    done_reg, done_next;
    logic [2:0]              idx_reg, idx_next;
    logic                    ov_reg, ov_next;
    res_beat_t               ob_reg, ob_next;

    logic                    out_free;
    logic [63:0]             bit_len;
    logic [31:0]             f_val, k_val, t_val, w_new;
    logic [5:0]              pos;
    logic [31:0]             pad_w [16];

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_beat  = ob_reg;
    assign bit_len   = 64'(count_reg) << 3;

    // message words with the pad byte at the fill point and zeros after
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
                pos = 6'(4 * i + b);
                if (pos < fill_reg) begin
                    pad_w[i][31-8*b -: 8] = w_reg[i][31-8*b -: 8];
                end else if (pos == fill_reg) begin
                    pad_w[i][31-8*b -: 8] = PAD_BYTE;
                end else begin
                    pad_w[i][31-8*b -: 8] = 8'h00;
                end
            end
        end
    end

    // one round
    always_comb begin
        if (rnd_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end else if (rnd_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (rnd_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb begin
        state_next = state_reg;
        tail_next  = tail_reg;
        rnd_next   = rnd_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        h_next = h_reg;
        w_next = w_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        q_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                q_ready = out_free;
                if (q_valid && out_free) begin
                    unique case (q_beat.cmd)
                        CMD_START: begin
                            h_next     = H_INIT;
                            count_next = '0;
                            fill_next  = '0;
                            done_next  = 1'b0;
                        end
                        CMD_ABSORB: begin
                            if (done_reg || count_reg == CAP) begin
                                ov_next = 1'b1;
                                ob_next = '{status: done_reg ? ST_DONE : ST_CAP,
                                            word_index: 3'd0, digest_word: 32'd0,
                                            last_word: 1'b1};
                            end else begin
                                w_next[fill_reg[5:2]][31-8*fill_reg[1:0] -: 8] = q_beat.data;
                                fill_next  = fill_reg + 6'd1;
                                count_next = count_reg + 1'b1;
                                if (fill_reg == 6'd63) begin
                                    a_next = h_reg[0]; b_next = h_reg[1]; c_next = h_reg[2];
                                    d_next = h_reg[3]; e_next = h_reg[4];
                                    rnd_next   = '0;
                                    tail_next  = TAIL_NONE;
                                    state_next = S_ROUND;
                                end
                            end
                        end
                        CMD_FINAL: begin
                            if (done_reg) begin
                                ov_next = 1'b1;
                                ob_next = '{status: ST_DONE, word_index: 3'd0,
                                            digest_word: 32'd0, last_word: 1'b1};
                            end else begin
                                w_next = pad_w;
                                if (fill_reg < LEN_POS) begin
                                    w_next[14] = bit_len[63:32];
                                    w_next[15] = bit_len[31:0];
                                    tail_next  = TAIL_EMIT;
                                end else begin
                                    tail_next  = TAIL_PAD2;
                                end
                                a_next = h_reg[0]; b_next = h_reg[1]; c_next = h_reg[2];
                                d_next = h_reg[3]; e_next = h_reg[4];
                                rnd_next   = '0;
                                state_next = S_ROUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ROUND: begin
                e_next = d_reg;
                d_next = c_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                b_next = a_reg;
                a_next = t_val;
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                unique case (tail_reg)
                    TAIL_NONE: state_next = S_IDLE;
                    TAIL_PAD2: state_next = S_PAD2;
                    TAIL_EMIT: begin
                        idx_next   = 3'd0;
                        done_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_PAD2: begin
                for (int i = 0; i < 14; i++) begin
                    w_next[i] = 32'd0;
                end
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
                a_next = h_reg[0]; b_next = h_reg[1]; c_next = h_reg[2];
                d_next = h_reg[3]; e_next = h_reg[4];
                rnd_next   = '0;
                tail_next  = TAIL_EMIT;
                state_next = S_ROUND;
            end
            S_EMIT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ob_next = '{status: ST_DIGEST, word_index: idx_reg,
                                digest_word: h_reg[idx_reg], last_word: (idx_reg == 3'd4)};
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd4) begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tail_reg  <= TAIL_NONE;
            rnd_reg   <= '0;
            h_reg     <= H_INIT;
            fill_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            rnd_reg   <= rnd_next;
            h_reg     <= h_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        d_reg  <= d_next;
        e_reg  <= e_next;
        w_reg  <= w_next;
        ob_reg <= ob_next;
    end

    `SHA1SH_ASSERT_NOW(a_round_range, state_reg == S_ROUND, rnd_reg < 7'd80)
    `SHA1SH_ASSERT_NOW(a_emit_done, state_reg == S_EMIT, done_reg)
    `SHA1SH_ASSERT_NOW(a_last_index,
        ov_reg && ob_reg.status == ST_DIGEST && ob_reg.last_word, ob_reg.word_index == 3'd4)
    `SHA1SH_ASSERT_NEXT(a_add_after_round,
        state_reg == S_ROUND && rnd_reg == 7'd79, state_reg == S_ADD)

endmodule
`default_nettype wire

### rtl/sha1_stream_hasher.sv
// sha1 stream hasher top level: command queue in front of the hashing core
// a byte that fills a block starts 80 rounds on one round unit, then the chain add
// finalize runs 80 rounds and the chain add, twice when the pad spills into a second block, then 5 beats
// absorb beats are held off while the single round unit works through a block
// reset: synchronous active-low aresetn loads the initial chaining value, clears count and queue
`default_nettype none
module sha1_stream_hasher #(
    parameter int COUNT_WIDTH = 61
) (
    input  wire         aclk,
    input  wire         aresetn,
    // command beats
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte[7:0]
    input  wire  [1:0]  s_tuser,   // command[1:0]
    // result beats
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // word_index[2:0], digest_word[34:3], zero fill above
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast    // last_word
);
    import sha1sh_pkg::*;

    logic       q_valid;
    logic       q_ready;
    cmd_beat_t  q_beat;
    res_beat_t  res;

    // front: accepts beats while not full, drops the unused command code, queues two deep
    sha1sh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_beat   (q_beat)
    );

    // back: buffer, padding, rounds and a registered result stage
    sha1sh_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_beat    (q_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (res)
    );

    // pack the result beat onto the stream
    assign m_tdata = {5'd0, res.digest_word, res.word_index};
    assign m_tuser = res.status;
    assign m_tlast = res.last_word;

endmodule
`default_nettype wire

### dv/sha1_result_checker.sv
// result checker for the sha1 stream hasher: predicts digests and compares result beats
`default_nettype none
module sha1_result_checker
    import sha1sh_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire  [1:0]  s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,
    input  wire  [1:0]  m_tuser,
    input  wire         m_tlast,
    output int          errors,
    output int          pending
);

    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    logic [63:0] msg_bytes;
    int          fill;
    logic        sealed;
    res_beat_t   digest_q [$];

    localparam logic [63:0] LEN_CAP = (64'd1 << 61) - 64'd1;

    function automatic void restart();
        for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
        msg_bytes = '0;
        fill      = 0;
        sealed    = 1'b0;
    endfunction

    // one 80-round compression of blk into chain
    function automatic void crunch();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++) begin
            x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d;          k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d;          k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function automatic void refuse(status_t st);
        res_beat_t r;
        r.status = st; r.word_index = '0; r.digest_word = '0; r.last_word = 1'b1;
        digest_q.push_back(r);
    endfunction

    function automatic void seal_message();
        logic [63:0] bits;
        res_beat_t   r;
        bits = msg_bytes << 3;
        blk[fill] = PAD_BYTE;
        fill++;
        // pad spills into a second block
        if (fill > 56) begin
            while (fill < 64) begin blk[fill] = 8'h00; fill++; end
            crunch();
            fill = 0;
        end
        while (fill < 56) begin blk[fill] = 8'h00; fill++; end
        for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
        crunch();
        for (int i = 0; i < 5; i++) begin
            r.status = ST_DIGEST; r.word_index = 3'(i);
            r.digest_word = chain[i]; r.last_word = (i == 4);
            digest_q.push_back(r);
        end
        fill   = 0;
        sealed = 1'b1;
    endfunction

    function automatic void predict(logic [1:0] cmd, logic [7:0] d);
        case (cmd)
            CMD_START: restart();
            CMD_ABSORB: begin
                if (sealed) refuse(ST_DONE);
                else if (msg_bytes >= LEN_CAP) refuse(ST_CAP);
                else begin
                    blk[fill] = d;
                    fill++;
                    msg_bytes++;
                    if (fill == 64) begin
                        crunch();
                        fill = 0;
                    end
                end
            end
            CMD_FINAL: begin
                if (sealed) refuse(ST_DONE);
                else seal_message();
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        res_beat_t want;
        if (!aresetn) begin
            restart();
            digest_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected result beat: status %0d word %0d data %h",
                           m_tuser, m_tdata[2:0], m_tdata[34:3]);
                    errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[2:0] !== want.word_index) begin
                        $error("word_index: expected %0d actual %0d",
                               want.word_index, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[34:3] !== want.digest_word) begin
                        $error("digest_word: expected %h actual %h",
                               want.digest_word, m_tdata[34:3]);
                        errors++;
                    end
                    if (m_tlast !== want.last_word) begin
                        $error("last_word: expected %0d actual %0d", want.last_word, m_tlast);
                        errors++;
                    end
                end
            end
            pending = digest_q.size();
        end
    end

endmodule
`default_nettype wire

### dv/tb_top.sv
// top of the sha1 stream hasher testbench: stimulus, flow control and verdict
`default_nettype none
module tb_top;
    import sha1sh_pkg::*;

    // unused command code, the block must ignore it
    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam int         RUN_LIMIT = 400000;
    localparam int         HOLD_LEN  = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    logic        quiet = 1'b0;    // no idling on either side while set
    logic        hold_req = 1'b0; // asks the receiver for a long hold-off
    int          hold_left = 0;

    always #10 aclk = ~aclk;

    sha1_stream_hasher u_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    sha1_result_checker u_chk (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .errors, .pending
    );

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("sha1_stream_hasher test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
            m_tready  = 1'b0;
        end else begin
            m_tready = aresetn && (quiet || $urandom_range(99) >= 11);
        end
    end

    // one command beat, called and returning at a falling edge
    task automatic push(input logic [1:0] cmd, input logic [7:0] d);
        if (!quiet) begin
            while ($urandom_range(99) < 11) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        sent++;
    endtask

    task automatic hash_message(input int len);
        push(CMD_START, 8'($urandom));
        for (int i = 0; i < len; i++) push(CMD_ABSORB, 8'($urandom));
        push(CMD_FINAL, 8'($urandom));
    endtask

    task automatic drain();
        wait (pending == 0);
        // a start or absorb may still be in the core with nothing expected
        repeat (200) @(negedge aclk);
    endtask

    initial begin
        int pick;
        int len;
        int msgs;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty message, byte extremes, refusals, ignored code
        push(CMD_FINAL, 8'h00);           // empty message straight from reset
        push(CMD_ABSORB, 8'hff);          // absorb after finalize is refused
        push(CMD_FINAL, 8'hff);           // second finalize is refused
        push(CMD_NONE, 8'h5a);
        push(CMD_START, 8'h00);
        push(CMD_ABSORB, 8'h00);
        push(CMD_ABSORB, 8'hff);
        push(CMD_ABSORB, 8'haa);
        push(CMD_ABSORB, 8'h55);
        push(CMD_NONE, 8'ha5);
        push(CMD_FINAL, 8'h00);
        push(CMD_START, 8'hff);           // start and one byte, then restart mid-message
        push(CMD_ABSORB, 8'h61);
        push(CMD_START, 8'h00);
        push(CMD_ABSORB, 8'h61);
        push(CMD_ABSORB, 8'h62);
        push(CMD_ABSORB, 8'h63);          // "abc"
        push(CMD_FINAL, 8'h00);
        push(CMD_ABSORB, 8'h01);

        // sender pauses until every digest is out
        drain();

        // long receiver hold-off while the sender keeps offering refused beats
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) push(CMD_ABSORB, 8'($urandom));
        push(CMD_FINAL, 8'h00);

        // random messages; block boundary lengths appear often
        msgs = 0;
        while (sent < 260) begin
            quiet = (msgs >= 2 && msgs < 6);
            pick  = $urandom_range(99);
            if (pick < 45)      len = $urandom_range(0, 6);
            else if (pick < 70) len = 52 + $urandom_range(0, 13);
            else if (pick < 78) len = 118 + $urandom_range(0, 4);
            else if (pick < 90) len = $urandom_range(7, 50);
            else                len = -1;
            if (len >= 0) begin
                hash_message(len);
            end else begin
                // noise: ignored code, absorb and finalize (refused after a sealed message) and an abandoned message
                push(CMD_NONE, 8'($urandom));
                push(CMD_ABSORB, 8'($urandom));
                push(CMD_FINAL, 8'($urandom));
                push(CMD_START, 8'($urandom));
                push(CMD_ABSORB, 8'($urandom));
            end
            msgs++;
            if (msgs % 10 == 0) drain();
        end
        quiet = 1'b0;

        wait (pending == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("sha1_stream_hasher test passed");
        end else begin
            $display("sha1_stream_hasher test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/sha1sh_pkg.sv
rtl/sha1sh_front.sv
rtl/sha1sh_core.sv
rtl/sha1_stream_hasher.sv
dv/sha1_result_checker.sv
dv/tb_top.sv
